/* rtl/sdhs_pkg.sv */
package sdhs_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_BUSY  = 2'd0,
        STATUS_DONE  = 2'd1,
        STATUS_ERROR = 2'd2
    } status_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_STEP_SIZE    = 3'd0,
        CFG_HOMING_SPEED = 3'd1,
        CFG_SPEED_TOL    = 3'd2,
        CFG_TORQUE_LIMIT = 3'd3,
        CFG_DIRECTION    = 3'd4
    } cfg_index_t;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 31;

    // Register reset values (Q16.16)
    localparam logic [30:0] STEP_SIZE_RST    = 31'd6554;
    localparam logic [30:0] HOMING_SPEED_RST = 31'd65536;
    localparam logic [30:0] SPEED_TOL_RST    = 31'd3277;
    localparam logic [30:0] TORQUE_LIMIT_RST = 31'd327680;

    // Window preload: 1000.0 rad/s in Q16.16
    localparam logic signed [31:0] PRELOAD_VEL = 32'sd65536000;

    localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

    // ceil(2^34 / 5): exact quotient for any 32-bit unsigned dividend
    localparam logic [31:0] DIV5_RECIP = 32'hCCCC_CCCD;

    typedef struct packed {
        logic signed [31:0] measured_pos;
        logic signed [31:0] measured_vel;
        logic signed [31:0] measured_torque;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] target_pos;
        logic signed [31:0] target_vel;
        status_t            status;
        logic signed [31:0] zero_position;
    } out_item_t;

    // Truncating divide by five via reciprocal multiply
    function automatic logic [30:0] div5(input logic [30:0] x);
        logic [62:0] prod;
        prod = 63'(x) * 63'(DIV5_RECIP);
        return 31'(prod[62:34]);
    endfunction

endpackage

/* rtl/sdhs_speed_filter.sv */
module sdhs_speed_filter #(
    parameter int WINDOW = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               update,
    input  logic signed [31:0] vel,
    input  logic [30:0]        speed_tol,
    output logic               stop
);
    import sdhs_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int SUM_W  = 32 + $clog2(WINDOW);
    localparam logic [SUM_W-1:0] SUM_RST = SUM_W'(64'(PRELOAD_VEL) * 64'(WINDOW));

    logic signed [31:0]       win_mem [WINDOW];
    logic [WINDOW-1:0]        win_valid_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic [SLOT_W-1:0]        slot_next;
    logic signed [31:0]       oldest_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic [SUM_W-1:0]         sum_mag;
    logic [SUM_W-1:0]         thresh;

    // Ring pointer wraps at the window length
    assign slot_next = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;

    // Running sum: drop the oldest sample, add the new one
    assign sum_next = sum_reg
                    - {{(SUM_W-32){oldest_reg[31]}}, oldest_reg}
                    + {{(SUM_W-32){vel[31]}}, vel};

    // |average| < tol  <=>  |sum| < tol * WINDOW
    assign sum_mag = sum_next[SUM_W-1] ? (~sum_next + 1'b1) : sum_next;
    assign thresh  = SUM_W'(speed_tol) * SUM_W'(WINDOW);
    assign stop    = sum_mag < thresh;

    // Sample store, no reset: unwritten entries read as the preload
    always_ff @(posedge aclk) begin
        if (update) begin
            win_mem[slot_reg] <= vel;
        end
    end

    // Pointer, sum, valid bits and prefetch of the next oldest sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_valid_reg <= '0;
            slot_reg      <= '0;
            oldest_reg    <= PRELOAD_VEL;
            sum_reg       <= SUM_RST;
        end else if (update) begin
            win_valid_reg[slot_reg] <= 1'b1;
            slot_reg                <= slot_next;
            sum_reg                 <= sum_next;
            oldest_reg              <= win_valid_reg[slot_next] ? win_mem[slot_next]
                                                                : PRELOAD_VEL;
        end
    end

    a_slot_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= SLOT_W'(WINDOW - 1))
        else $error("window slot out of range");

    a_slot_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        update |=> slot_reg != $past(slot_reg))
        else $error("window slot did not move on update");

endmodule

/* rtl/stall_detect_homing_step_unit.sv */
// Path: input register, then result register (loaded once free or draining) to m_.
// Throughput: one transaction per cycle while m_ready holds; two register stages
// (input and result) let a new one in while a finished result waits for m_ready.
// Speed window: running sum over WINDOW samples, one read and one write per update.
// Reset (aresetn, synchronous, active low): pipeline empty, registers to defaults,
// window preloaded with 1000 rad/s, calibrated zero cleared.
module stall_detect_homing_step_unit #(
    parameter int WINDOW = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [sdhs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [sdhs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  sdhs_pkg::in_item_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output sdhs_pkg::out_item_t            m_data
);
    import sdhs_pkg::*;

    logic [30:0]        step_size_reg;
    logic [30:0]        slow_step_reg;
    logic [30:0]        homing_speed_reg;
    logic [30:0]        speed_tol_reg;
    logic [30:0]        torque_limit_reg;
    logic               direction_reg;

    logic               in_valid_reg;
    in_item_t           in_data_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;
    out_item_t          out_data_next;
    logic signed [31:0] calib_zero_reg;

    logic               advance;
    logic               link_lost;
    logic               stop;
    logic               filt_update;
    logic signed [32:0] trq_ext;
    logic [32:0]        trq_mag;
    logic [30:0]        step;
    logic signed [32:0] pos_wide;
    logic signed [31:0] pos_sat;
    logic signed [31:0] vel_cmd;

    // Configuration writes; slowed step is precomputed at write time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg    <= STEP_SIZE_RST;
            slow_step_reg    <= div5(STEP_SIZE_RST);
            homing_speed_reg <= HOMING_SPEED_RST;
            speed_tol_reg    <= SPEED_TOL_RST;
            torque_limit_reg <= TORQUE_LIMIT_RST;
            direction_reg    <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_STEP_SIZE: begin
                    step_size_reg <= cfg_wdata;
                    slow_step_reg <= div5(cfg_wdata);
                end
                CFG_HOMING_SPEED: homing_speed_reg <= cfg_wdata;
                CFG_SPEED_TOL:    speed_tol_reg    <= cfg_wdata;
                CFG_TORQUE_LIMIT: torque_limit_reg <= cfg_wdata;
                CFG_DIRECTION:    direction_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Handshake: input stage moves on when the result stage is free or drains
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Link-loss check and torque-dependent step
    assign link_lost = in_data_reg.measured_pos == '0;
    assign trq_ext   = {in_data_reg.measured_torque[31], in_data_reg.measured_torque};
    assign trq_mag   = trq_ext[32] ? 33'(-trq_ext) : 33'(trq_ext);
    assign step      = (trq_mag > {2'b00, torque_limit_reg}) ? slow_step_reg : step_size_reg;

    // Target position one step ahead, saturated to 32 bits, and velocity command
    always_comb begin
        if (direction_reg) begin
            pos_wide = {in_data_reg.measured_pos[31], in_data_reg.measured_pos}
                     - $signed({2'b00, step});
            vel_cmd  = -$signed({1'b0, homing_speed_reg});
        end else begin
            pos_wide = {in_data_reg.measured_pos[31], in_data_reg.measured_pos}
                     + $signed({2'b00, step});
            vel_cmd  = $signed({1'b0, homing_speed_reg});
        end
        if (pos_wide[32] != pos_wide[31]) begin
            pos_sat = pos_wide[32] ? POS_MIN : POS_MAX;
        end else begin
            pos_sat = pos_wide[31:0];
        end
    end

    assign filt_update = advance && !link_lost;

    sdhs_speed_filter #(
        .WINDOW (WINDOW)
    ) u_filter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .update    (filt_update),
        .vel       (in_data_reg.measured_vel),
        .speed_tol (speed_tol_reg),
        .stop      (stop)
    );

    // Result assembly
    always_comb begin
        if (link_lost) begin
            out_data_next.target_pos    = '0;
            out_data_next.target_vel    = '0;
            out_data_next.status        = STATUS_ERROR;
            out_data_next.zero_position = calib_zero_reg;
        end else begin
            out_data_next.target_pos    = pos_sat;
            out_data_next.target_vel    = vel_cmd;
            out_data_next.status        = stop ? STATUS_DONE : STATUS_BUSY;
            out_data_next.zero_position = stop ? in_data_reg.measured_pos : calib_zero_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    // Calibrated zero latches on a passing stop test
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calib_zero_reg <= '0;
        end else if (filt_update && stop) begin
            calib_zero_reg <= in_data_reg.measured_pos;
        end
    end

    a_fill_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("pending transaction did not reach the result stage");

    a_ready_low_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled with room in the pipeline");

    a_error_zero_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.status == STATUS_ERROR
            |-> out_data_reg.target_pos == '0 && out_data_reg.target_vel == '0)
        else $error("link-lost result carries a non-zero command");

    a_zero_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_data_reg.zero_position == calib_zero_reg)
        else $error("reported zero differs from latched zero");

endmodule

/* tb/homing_step_checker.sv */
// Watches both channels and the register port of the homing step unit,
// predicts each command from its own copy of the registers and speed window,
// and compares every result transaction against the oldest prediction.
module homing_step_checker #(
    parameter int WINDOW = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [sdhs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [sdhs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  sdhs_pkg::in_item_t              s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  sdhs_pkg::out_item_t             m_data,
    output int                              mismatches,
    output int                              pending,
    output int                              stops_seen,
    output int                              losses_seen
);
    import sdhs_pkg::*;

    localparam longint SLOW_DIV = 5;
    localparam int     REPORT_LIMIT = 10;

    // Shadow registers
    logic [30:0] step_reg;
    logic [30:0] speed_reg;
    logic [30:0] tol_reg;
    logic [30:0] torque_reg;
    logic        dir_reg;

    // Shadow speed window and calibration
    longint vel_ring [WINDOW];
    longint vel_sum;
    int     ring_slot;
    longint cal_zero;

    out_item_t expected_cmds [$];

    function automatic longint clamp32(input longint v);
        if (v > longint'(POS_MAX))
            return longint'(POS_MAX);
        if (v < longint'(POS_MIN))
            return longint'(POS_MIN);
        return v;
    endfunction

    // One control tick: command, window update and stop test
    task automatic predict_homing_cmd(input in_item_t it, output out_item_t res);
        longint pos;
        longint vel;
        longint trq;
        longint stride;
        longint tpos;
        longint tvel;
        longint mag;
        pos = it.measured_pos;
        vel = it.measured_vel;
        trq = it.measured_torque;
        // link lost: zero command, filter untouched
        if (pos == 0) begin
            res.target_pos    = '0;
            res.target_vel    = '0;
            res.status        = STATUS_ERROR;
            res.zero_position = cal_zero[31:0];
            return;
        end
        if (trq < 0)
            trq = -trq;
        stride = longint'(step_reg);
        if (trq > longint'(torque_reg))
            stride = longint'(step_reg) / SLOW_DIV;
        if (!dir_reg) begin
            tpos = clamp32(pos + stride);
            tvel = longint'(speed_reg);
        end else begin
            tpos = clamp32(pos - stride);
            tvel = -longint'(speed_reg);
        end
        vel_sum = vel_sum - vel_ring[ring_slot] + vel;
        vel_ring[ring_slot] = vel;
        ring_slot = (ring_slot + 1) % WINDOW;
        mag = (vel_sum < 0) ? -vel_sum : vel_sum;
        if (mag < longint'(tol_reg) * WINDOW) begin
            cal_zero   = pos;
            res.status = STATUS_DONE;
        end else begin
            res.status = STATUS_BUSY;
        end
        res.target_pos    = tpos[31:0];
        res.target_vel    = tvel[31:0];
        res.zero_position = cal_zero[31:0];
    endtask

    // Sampled at the rising edge; the stimulus side changes on the falling edge
    always @(posedge aclk) begin : monitor
        out_item_t predicted;
        out_item_t want;
        if (!aresetn) begin
            step_reg   = STEP_SIZE_RST;
            speed_reg  = HOMING_SPEED_RST;
            tol_reg    = SPEED_TOL_RST;
            torque_reg = TORQUE_LIMIT_RST;
            dir_reg    = 1'b0;
            for (int i = 0; i < WINDOW; i++)
                vel_ring[i] = longint'(PRELOAD_VEL);
            vel_sum     = longint'(PRELOAD_VEL) * WINDOW;
            ring_slot   = 0;
            cal_zero    = 0;
            expected_cmds.delete();
            mismatches  = 0;
            pending     = 0;
            stops_seen  = 0;
            losses_seen = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_STEP_SIZE:    step_reg = cfg_wdata;
                    CFG_HOMING_SPEED: speed_reg = cfg_wdata;
                    CFG_SPEED_TOL:    tol_reg = cfg_wdata;
                    CFG_TORQUE_LIMIT: torque_reg = cfg_wdata;
                    CFG_DIRECTION:    dir_reg = cfg_wdata[0];
                    default: ;
                endcase
            end
            // result side first: a result never belongs to this edge's input
            if (m_valid && m_ready) begin
                if (expected_cmds.size() == 0) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("%s pos %0d vel %0d status %0d zero %0d",
                                 "unexpected result transaction:",
                                 m_data.target_pos, m_data.target_vel, m_data.status,
                                 m_data.zero_position);
                    mismatches++;
                end else begin
                    want = expected_cmds.pop_front();
                    if (m_data.target_pos !== want.target_pos ||
                        m_data.target_vel !== want.target_vel ||
                        m_data.status !== want.status ||
                        m_data.zero_position !== want.zero_position) begin
                        if (mismatches < REPORT_LIMIT)
                            $display({"result mismatch: expected pos %0d vel %0d ",
                                      "status %0d zero %0d, got pos %0d vel %0d ",
                                      "status %0d zero %0d"},
                                     want.target_pos, want.target_vel, want.status,
                                     want.zero_position, m_data.target_pos,
                                     m_data.target_vel, m_data.status, m_data.zero_position);
                        mismatches++;
                    end
                    if (want.status == STATUS_DONE)
                        stops_seen++;
                    if (want.status == STATUS_ERROR)
                        losses_seen++;
                end
            end
            if (s_valid && s_ready) begin
                predict_homing_cmd(s_data, predicted);
                expected_cmds.push_back(predicted);
            end
            pending = expected_cmds.size();
        end
    end

endmodule

/* tb/stall_detect_homing_step_unit_tb.sv */
module stall_detect_homing_step_unit_tb;
    import sdhs_pkg::*;

    localparam int WINDOW = 8;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;

    int mismatches;
    int pending;
    int stops_seen;
    int losses_seen;

    int send_idle_pct;
    int recv_idle_pct;
    int sent;
    int settings;
    int track_pos;
    logic [30:0] tol_now;
    logic [30:0] trq_now;

    stall_detect_homing_step_unit #(.WINDOW(WINDOW)) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    homing_step_checker #(.WINDOW(WINDOW)) i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .pending     (pending),
        .stops_seen  (stops_seen),
        .losses_seen (losses_seen)
    );

    // Clock, period 2
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Watchdog
    initial begin
        #600000;
        $display("FAIL stall_detect_homing_step_unit");
        $finish;
    end

    // Result side back-pressure
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic in_item_t mk(input logic [31:0] p, input logic [31:0] v,
                                    input logic [31:0] t);
        in_item_t it;
        it.measured_pos    = p;
        it.measured_vel    = v;
        it.measured_torque = t;
        return it;
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [30:0] val);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    // Hold the sender until every outstanding command has come back
    task automatic settle();
        while (pending != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic load_settings(input logic [30:0] st, input logic [30:0] sp,
                                 input logic [30:0] tl, input logic [30:0] tq,
                                 input logic dir);
        settle();
        write_reg(CFG_STEP_SIZE, st);
        write_reg(CFG_HOMING_SPEED, sp);
        write_reg(CFG_SPEED_TOL, tl);
        write_reg(CFG_TORQUE_LIMIT, tq);
        write_reg(CFG_DIRECTION, {30'd0, dir});
        tol_now = tl;
        trq_now = tq;
        settings++;
    endtask

    // Entered and left just after a falling edge
    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = it;
        do
            @(posedge aclk);
        while (!s_ready);
        @(negedge aclk);
        s_valid = 1'b0;
        sent++;
    endtask

    task automatic random_settings();
        logic [30:0] st;
        logic [30:0] sp;
        logic [30:0] tl;
        logic [30:0] tq;
        case ($urandom_range(5))
            0:       st = '0;
            1:       st = '1;
            default: st = 31'($urandom_range(0, 200000));
        endcase
        sp = 31'($urandom());
        case ($urandom_range(4))
            0:       tl = '0;
            1:       tl = '1;
            default: tl = 31'($urandom_range(1, 50000));
        endcase
        case ($urandom_range(4))
            0:       tq = '0;
            1:       tq = '1;
            default: tq = 31'($urandom_range(0, 1000000));
        endcase
        load_settings(st, sp, tl, tq, 1'($urandom_range(1)));
    endtask

    // One burst of ticks: approach at speed, a stall against the stop, or noise
    task automatic run_segment();
        int kind;
        int n;
        int vi;
        int ti;
        int pi;
        int bound;
        int lim;
        int r;
        kind = $urandom_range(9);
        if (kind < 4)
            n = $urandom_range(1, 12);
        else if (kind < 8)
            n = $urandom_range(WINDOW, 2 * WINDOW);
        else
            n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
            track_pos = track_pos + int'($urandom_range(0, 2000)) - 1000;
            r = $urandom_range(24);
            if (r == 0)
                pi = 0;
            else if (r == 1)
                pi = 32'h7FFF_FFFF - int'($urandom_range(0, 3));
            else if (r == 2)
                pi = 32'h8000_0000 + int'($urandom_range(0, 3));
            else
                pi = track_pos;
            if (kind < 4) begin
                // moving freely, torque mostly under the limit
                vi = $urandom_range(1) ? int'($urandom())
                                       : int'($urandom_range(0, 2000000)) - 1000000;
                lim = (trq_now > 1000000) ? 1000000 : int'(trq_now);
                ti = ($urandom_range(3) == 0) ? int'($urandom())
                                              : int'($urandom_range(0, lim));
            end else if (kind < 8) begin
                // pressed against the stop: speed near zero, torque high
                bound = (tol_now < 4096) ? int'(tol_now) : 4096;
                vi = int'($urandom_range(0, 2 * bound)) - bound;
                ti = (trq_now != '1 && $urandom_range(1)) ? int'(trq_now) + 1
                                                          : int'($urandom());
            end else begin
                pi = $urandom();
                vi = $urandom();
                ti = $urandom();
            end
            if ($urandom_range(1))
                ti = -ti;
            send_item(mk(pi, vi, ti));
        end
    endtask

    task automatic random_phase(input int s_pct, input int r_pct, input int count);
        int target;
        int segs;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        target = sent + count;
        segs = 0;
        while (sent < target) begin
            if (segs % 20 == 0)
                random_settings();
            else if ($urandom_range(59) == 0)
                settle();
            run_segment();
            segs++;
        end
    endtask

    // Stimulus and verdict
    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        sent      = 0;
        settings  = 0;
        track_pos = 12345;
        tol_now   = SPEED_TOL_RST;
        trq_now   = TORQUE_LIMIT_RST;
        send_idle_pct = 31;
        recv_idle_pct = 83;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings: link loss, saturation, torque edges, stop threshold
        send_item(mk(0, 0, 0));
        send_item(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
        send_item(mk(1, 32'h8000_0000, 32'h8000_0000));
        send_item(mk(-1, 0, 327680));
        send_item(mk(100, 0, 327681));
        send_item(mk(200, 0, -327681));
        for (int k = 3; k <= 8; k++)
            send_item(mk(k * 100, 0, 0));
        // window now all zero: one sample right at the threshold, then just under
        send_item(mk(900, 26216, 0));
        send_item(mk(1000, -1, 0));
        send_item(mk(0, 5, 5));

        // Largest step, speed and tolerance, clockwise
        load_settings('1, '1, '1, '0, 1'b1);
        send_item(mk(32'h8000_0000, 32'h7FFF_FFFF, 1));
        send_item(mk(32'h8000_0001, 32'h8000_0000, 0));
        send_item(mk(32'h7FFF_FFFF, 0, -1));

        // Everything zero except the torque limit
        load_settings('0, '0, '0, '1, 1'b0);
        send_item(mk(5, 0, 32'h8000_0000));
        send_item(mk(-5, 0, 32'h7FFF_FFFF));
        send_item(mk(0, 0, 0));

        random_phase(31, 83, 443);
        random_phase(83, 31, 443);
        random_phase(0, 0, 443);

        settle();
        repeat (10) @(negedge aclk);
        $display("Checked %0d transactions over %0d register settings,", sent, settings);
        $display("including %0d stop detections and %0d link-loss ticks.",
                 stops_seen, losses_seen);
        if (mismatches == 0 && pending == 0) begin
            $display("PASS stall_detect_homing_step_unit");
        end else begin
            $display("FAIL stall_detect_homing_step_unit");
        end
        $finish;
    end

endmodule
